// ===== hdl/dofl_pkg.sv =====
package dofl_pkg;

  // Number formats
  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 40;          // wide signed accumulator for saturating sums
  localparam int CORR_W    = 18;          // ln(1 + exp(-d)) result, never above ln 2
  localparam int DIV_W     = 62;          // dividend / shifted divisor width
  localparam int DIV_QW    = 30;          // widest quotient the divider produces
  localparam int DIV_CW    = 5;           // quotient bit counter

  localparam logic [4:0]  VISIT_LIMIT = 5'd16;
  localparam logic [29:0] LN2_Q30     = 30'd744261118;

  localparam logic signed [31:0] LOG_NEG = 32'sh8000_0000;
  localparam logic signed [31:0] LOG_POS = 32'sh7fff_ffff;

  // Request / response of the ln(1 + exp(-d)) engine
  typedef struct packed {
    logic        start;
    logic [31:0] d;
  } corr_req_t;

  typedef struct packed {
    logic              done;
    logic [CORR_W-1:0] value;
  } corr_rsp_t;

  // Request / response of the shift-subtract divider
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den_sh;   // divisor already aligned to the top quotient bit
    logic [DIV_CW-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] q;
  } div_rsp_t;

  // Saturate a wide signed value to the 32-bit log range
  function automatic logic signed [31:0] sat_log(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > ACC_W'(LOG_POS)) begin
      r = LOG_POS;
    end else if (v < ACC_W'(LOG_NEG)) begin
      r = LOG_NEG;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_log(input logic signed [31:0] a);
    return {{(ACC_W-32){a[31]}}, a};
  endfunction

  // Saturating add of two logs
  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat_log(ext_log(a) + ext_log(b));
  endfunction

  function automatic logic [4:0] clamp_cnt(input logic [4:0] c);
    return (c > VISIT_LIMIT) ? VISIT_LIMIT : c;
  endfunction

  // floor(2^31 / k) for the small divisors of both series
  function automatic logic [31:0] recip_tab(input logic [4:0] k);
    logic [31:0] r;
    case (k)
      5'd1:    r = 32'd2147483648;
      5'd2:    r = 32'd1073741824;
      5'd3:    r = 32'd715827882;
      5'd4:    r = 32'd536870912;
      5'd5:    r = 32'd429496729;
      5'd6:    r = 32'd357913941;
      5'd7:    r = 32'd306783378;
      5'd8:    r = 32'd268435456;
      5'd9:    r = 32'd238609294;
      5'd10:   r = 32'd214748364;
      5'd11:   r = 32'd195225786;
      5'd12:   r = 32'd178956970;
      5'd13:   r = 32'd165191049;
      5'd15:   r = 32'd143165576;
      5'd17:   r = 32'd126322567;
      5'd19:   r = 32'd113025455;
      5'd21:   r = 32'd102261126;
      5'd23:   r = 32'd93368854;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/dofl_div.sv =====
module dofl_div (
  input  logic               clk,
  input  logic               rst_n,
  input  dofl_pkg::div_req_t req,
  output dofl_pkg::div_rsp_t rsp
);
  import dofl_pkg::*;

  logic              busy_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dsh_r;
  logic [DIV_QW-1:0] q_r;

  assign rsp.done = busy_r && (cnt_r == '0);
  assign rsp.q    = q_r;

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.nbits;
      rem_r  <= req.num;
      dsh_r  <= req.den_sh;
      q_r    <= '0;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[DIV_QW-2:0], 1'b1};
        end else begin
          q_r   <= {q_r[DIV_QW-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // the sequencer never restarts a division in flight
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

// ===== hdl/dofl_corr.sv =====
module dofl_corr (
  input  logic                clk,
  input  logic                rst_n,
  input  dofl_pkg::corr_req_t req,
  output dofl_pkg::corr_rsp_t rsp
);
  import dofl_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE, C_NA, C_NB, C_NC, C_TA, C_TB, C_TC, C_E, C_DIVZ,
    C_Z2, C_Z3, C_SA, C_SB, C_SC, C_FIN, C_DONE
  } cstate_t;

  localparam logic [32:0] CORR_LIMIT = 33'd32 << FRAC_BITS;
  localparam logic [4:0]  TAYLOR_LAST = 5'd12;
  localparam logic [4:0]  SERIES_LAST = 5'd23;
  localparam logic [DIV_CW-1:0] Z_QBITS = 5'd30;
  // floor(2^46 / ln2 in Q30): d * this >> 32 is floor(d / ln2) or one below
  localparam logic [31:0] LN2_RECIP = 32'd94548;

  cstate_t            state_r;
  logic [20:0]        d_r;
  logic [5:0]         n_r;
  logic [29:0]        r_r;
  logic [30:0]        term_r;
  logic signed [32:0] sum_r;
  logic [4:0]         k_r;
  logic [30:0]        t0_r;
  logic [63:0]        mul_r;
  logic [29:0]        z_r;
  logic [29:0]        z2_r;
  logic [29:0]        p_r;
  logic [33:0]        acc_r;
  logic [CORR_W-1:0]  res_r;

  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic        too_big;
  logic [35:0] r_red;
  logic [35:0] r_sub;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [31:0] recip_k;
  logic [31:0] qe;
  logic [30:0] dk_x;
  logic [36:0] qk;
  logic        fix;
  logic [30:0] dk_q;
  logic [31:0] e_v;
  logic [34:0] acc2;
  logic [34:0] rnd;

  dofl_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign too_big = {1'b0, req.d} >= CORR_LIMIT;

  // Range reduction remainder: d in Q30 less n * ln2, at most one ln2 too many
  assign r_red = (36'(d_r) << (30 - FRAC_BITS)) - mul_r[35:0];
  assign r_sub = r_red - {6'b0, LN2_Q30};

  // Divider request: e / (2 + e) for the series argument
  assign e_v = sum_r[32] ? 32'd0 : (sum_r[31:0] >> n_r);
  always_comb begin
    div_req.start  = (state_r == C_E);
    div_req.num    = DIV_W'(e_v) << 30;
    div_req.den_sh = DIV_W'({1'b0, e_v} + 33'd2147483648) << (Z_QBITS - 1'b1);
    div_req.nbits  = Z_QBITS;
  end

  // Shared multiplier operands
  assign recip_k = recip_tab(k_r);
  always_comb begin
    case (state_r)
      C_NA:    begin mul_a = {11'b0, d_r};          mul_b = LN2_RECIP;         end
      C_NB:    begin mul_a = {26'b0, mul_r[37:32]}; mul_b = {2'b0, LN2_Q30};   end
      C_TA:    begin mul_a = {1'b0, term_r};       mul_b = {2'b0, r_r};       end
      C_TB:    begin mul_a = {1'b0, mul_r[60:30]}; mul_b = recip_k;           end
      C_Z2:    begin mul_a = {2'b0, z_r};          mul_b = {2'b0, z_r};       end
      C_SA:    begin mul_a = {2'b0, p_r};          mul_b = recip_k;           end
      C_SB:    begin mul_a = {2'b0, p_r};          mul_b = {2'b0, z2_r};      end
      default: begin mul_a = '0;                   mul_b = '0;                end
    endcase
  end
  assign prod = mul_a * mul_b;

  // x / k by reciprocal, then one correction step
  assign qe   = mul_r[62:31];
  assign dk_x = (state_r == C_TC) ? t0_r : {1'b0, p_r};
  assign qk   = {5'b0, qe} * {32'b0, k_r};
  assign fix  = {6'b0, dk_x} >= (qk + {32'b0, k_r});
  assign dk_q = qe[30:0] + {30'b0, fix};

  // Round the Q30 series sum to the log format
  assign acc2 = {acc_r, 1'b0};
  assign rnd  = (acc2 + (35'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

  assign rsp.done  = (state_r == C_DONE);
  assign rsp.value = res_r;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      case (state_r)
        C_IDLE: begin
          if (req.start) begin
            if (too_big) begin
              res_r   <= '0;
              state_r <= C_DONE;
            end else begin
              d_r     <= req.d[20:0];
              state_r <= C_NA;
            end
          end
        end
        // n = floor(d / ln2) by reciprocal estimate
        C_NA: begin
          mul_r   <= prod;
          state_r <= C_NB;
        end
        C_NB: begin
          n_r     <= mul_r[37:32];
          mul_r   <= prod;
          state_r <= C_NC;
        end
        C_NC: begin
          if (r_red >= {6'b0, LN2_Q30}) begin
            n_r <= n_r + 6'd1;
            r_r <= r_sub[29:0];
          end else begin
            r_r <= r_red[29:0];
          end
          term_r  <= 31'h4000_0000;
          sum_r   <= 33'sh0_4000_0000;
          k_r     <= 5'd1;
          state_r <= C_TA;
        end
        C_TA: begin
          mul_r   <= prod;
          state_r <= C_TB;
        end
        C_TB: begin
          t0_r    <= mul_r[60:30];
          mul_r   <= prod;
          state_r <= C_TC;
        end
        C_TC: begin
          // exp(-r) Taylor terms alternate in sign
          term_r <= dk_q;
          if (k_r[0]) begin
            sum_r <= sum_r - $signed({2'b0, dk_q});
          end else begin
            sum_r <= sum_r + $signed({2'b0, dk_q});
          end
          if (k_r == TAYLOR_LAST) begin
            state_r <= C_E;
          end else begin
            k_r     <= k_r + 5'd1;
            state_r <= C_TA;
          end
        end
        C_E: begin
          state_r <= C_DIVZ;
        end
        C_DIVZ: begin
          if (div_rsp.done) begin
            z_r     <= div_rsp.q;
            state_r <= C_Z2;
          end
        end
        C_Z2: begin
          mul_r   <= prod;
          state_r <= C_Z3;
        end
        C_Z3: begin
          z2_r    <= mul_r[59:30];
          p_r     <= z_r;
          acc_r   <= '0;
          k_r     <= 5'd1;
          state_r <= C_SA;
        end
        C_SA: begin
          mul_r   <= prod;
          state_r <= C_SB;
        end
        C_SB: begin
          acc_r   <= acc_r + {3'b0, dk_q};
          mul_r   <= prod;
          state_r <= C_SC;
        end
        C_SC: begin
          p_r <= mul_r[59:30];
          if (k_r == SERIES_LAST) begin
            state_r <= C_FIN;
          end else begin
            k_r     <= k_r + 5'd2;
            state_r <= C_SA;
          end
        end
        C_FIN: begin
          res_r   <= rnd[CORR_W-1:0];
          state_r <= C_DONE;
        end
        C_DONE: begin
          state_r <= C_IDLE;
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

  // a division only completes while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == C_DIVZ))
    else $error("division finished outside a wait state");

endmodule

// ===== hdl/dynamic_occupancy_forward_loglik.sv =====
// Two-state dynamic occupancy forward likelihood, one season per transfer.
// Input channel (in_valid / in_stall): one season of one site. A season with
// in_first_season set loads the four logits and restarts the site; the block
// keeps the forward log pair, the six log probabilities and the running
// log-likelihood between seasons. Counts above the visit limit are clamped.
// Output channel (out_valid / out_stall): one site log-likelihood (Q16.16)
// after each season flagged in_last_season; other seasons give no transfer.
// Each log-sigmoid pair or log-sum-exp is one pass of the shared
// ln(1 + exp(-d)) engine, which goes straight to its result when d is out of
// range; else it does range reduction, two twelve-term series on the shared
// multiplier, and a 30-bit bit-serial divide for the series argument.
// in_stall is high from the accepted transfer until the season is done; a
// season with visits but no detection adds one normalising pass, a first
// season adds four passes, and a last season skips the two transition
// passes. in_stall is low in idle before the next season is taken.
// A result waits in the output register while out_stall is high; the next
// season is still taken and only blocks if it reaches its own result first.
// Reset (synchronous, rst_n low) clears the forward state, the terms and the
// running sum to zero and drops any pending result.
module dynamic_occupancy_forward_loglik (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_first_season,
  input  logic               in_last_season,
  input  logic signed [23:0] in_eta_init_occ,
  input  logic signed [23:0] in_eta_detect,
  input  logic signed [23:0] in_eta_colonise,
  input  logic signed [23:0] in_eta_extinct,
  input  logic [4:0]         in_visit_count,
  input  logic [4:0]         in_det_count,
  input  logic [4:0]         in_nondet_count,
  input  logic               in_any_detected,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_site_loglik
);
  import dofl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ETA_GO, S_ETA_WAIT, S_OBS, S_DET_A, S_DET_B, S_DET_C,
    S_ND_A, S_ND_B, S_ND_WAIT, S_ND_C, S_TR_GO, S_TR_W1, S_TR_GO2, S_TR_W2, S_EMIT
  } state_t;

  state_t                   state_r;
  logic                     last_r;
  logic                     anyd_r;
  logic [4:0]               nv_r;
  logic [4:0]               k1_r;
  logic [4:0]               k0_r;
  logic signed [23:0]       eta_r [4];
  logic [1:0]               idx_r;
  logic signed [31:0]       a_occ_r;
  logic signed [31:0]       a_un_r;
  logic signed [31:0]       run_r;
  logic signed [31:0]       lp_r [6];
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [31:0]       t1_r;
  logic signed [31:0]       nrm_r;
  logic signed [31:0]       hi_r;
  logic signed [31:0]       tmp_r;
  logic                     out_valid_r;
  logic signed [31:0]       out_loglik_r;

  corr_req_t               corr_req;
  corr_rsp_t               corr_rsp;
  logic signed [23:0]      eta_x;
  logic signed [31:0]      eta_w;
  logic [31:0]             eta_abs;
  logic signed [31:0]      c_w;
  logic signed [31:0]      ls_v;
  logic signed [31:0]      l1m_v;
  logic [4:0]              sm_cnt;
  logic signed [31:0]      sm_lp;
  logic signed [ACC_W-1:0] sm_prod;
  logic signed [31:0]      t1_v;
  logic signed [31:0]      lse_a;
  logic signed [31:0]      lse_b;
  logic signed [31:0]      lse_hi;
  logic signed [31:0]      lse_lo;
  logic [32:0]             lse_d;
  logic signed [31:0]      lse_res;
  logic signed [31:0]      neg_nrm;

  dofl_corr u_corr (
    .clk (clk),
    .rst_n (rst_n),
    .req (corr_req),
    .rsp (corr_rsp)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_site_loglik = out_loglik_r;

  // Log-sigmoid pair from one correction value
  assign eta_x   = eta_r[idx_r];
  assign eta_w   = {{8{eta_x[23]}}, eta_x};
  assign eta_abs = eta_x[23] ? 32'(-eta_w) : 32'(eta_w);
  assign c_w     = $signed({{(32-CORR_W){1'b0}}, corr_rsp.value});
  assign ls_v    = eta_x[23] ? (eta_w - c_w) : -c_w;
  assign l1m_v   = (eta_x[23] || eta_x == 24'sd0) ? -c_w : (-eta_w - c_w);

  // Count times log-probability for the observation update
  always_comb begin
    case (state_r)
      S_DET_A: begin sm_cnt = k1_r; sm_lp = lp_r[0]; end
      S_DET_B: begin sm_cnt = k0_r; sm_lp = lp_r[1]; end
      S_ND_A:  begin sm_cnt = nv_r; sm_lp = lp_r[1]; end
      default: begin sm_cnt = '0;   sm_lp = '0;      end
    endcase
  end
  assign sm_prod = $signed({{(ACC_W-5){1'b0}}, sm_cnt}) * ext_log(sm_lp);
  assign t1_v    = sat_log(acc_r);

  // Log-sum-exp operands
  always_comb begin
    case (state_r)
      S_ND_B:   begin lse_a = t1_v;                   lse_b = a_un_r;                 end
      S_TR_GO:  begin lse_a = sadd(a_occ_r, lp_r[5]); lse_b = sadd(a_un_r, lp_r[2]); end
      S_TR_GO2: begin lse_a = sadd(a_occ_r, lp_r[4]); lse_b = sadd(a_un_r, lp_r[3]); end
      default:  begin lse_a = '0;                     lse_b = '0;                     end
    endcase
  end
  assign lse_hi  = (lse_a > lse_b) ? lse_a : lse_b;
  assign lse_lo  = (lse_a > lse_b) ? lse_b : lse_a;
  assign lse_d   = {lse_hi[31], lse_hi} - {lse_lo[31], lse_lo};
  assign lse_res = sat_log(ext_log(hi_r) + ext_log(c_w));
  assign neg_nrm = sat_log(-ext_log(nrm_r));

  assign corr_req.start = (state_r == S_ETA_GO) || (state_r == S_ND_B) ||
                          (state_r == S_TR_GO && !last_r) || (state_r == S_TR_GO2);
  assign corr_req.d     = (state_r == S_ETA_GO) ? eta_abs : lse_d[31:0];

  // Season sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      a_occ_r     <= '0;
      a_un_r      <= '0;
      run_r       <= '0;
      for (int i = 0; i < 6; i++) begin
        lp_r[i] <= '0;
      end
    end else begin
      // the emit step handles the output register itself
      if (out_valid_r && !out_stall && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            last_r   <= in_last_season;
            anyd_r   <= in_any_detected;
            nv_r     <= clamp_cnt(in_visit_count);
            k1_r     <= clamp_cnt(in_det_count);
            k0_r     <= clamp_cnt(in_nondet_count);
            eta_r[0] <= in_eta_detect;
            eta_r[1] <= in_eta_colonise;
            eta_r[2] <= in_eta_extinct;
            eta_r[3] <= in_eta_init_occ;
            idx_r    <= 2'd0;
            state_r  <= in_first_season ? S_ETA_GO : S_OBS;
          end
        end
        S_ETA_GO: begin
          state_r <= S_ETA_WAIT;
        end
        S_ETA_WAIT: begin
          if (corr_rsp.done) begin
            case (idx_r)
              2'd0: begin lp_r[0] <= ls_v; lp_r[1] <= l1m_v; end
              2'd1: begin lp_r[2] <= ls_v; lp_r[3] <= l1m_v; end
              2'd2: begin lp_r[4] <= ls_v; lp_r[5] <= l1m_v; end
              default: begin
                a_occ_r <= ls_v;
                a_un_r  <= l1m_v;
                run_r   <= '0;
              end
            endcase
            if (idx_r == 2'd3) begin
              state_r <= S_OBS;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= S_ETA_GO;
            end
          end
        end
        S_OBS: begin
          if (nv_r == '0) begin
            state_r <= S_TR_GO;
          end else if (anyd_r) begin
            state_r <= S_DET_A;
          end else begin
            state_r <= S_ND_A;
          end
        end
        // known occupied
        S_DET_A: begin
          acc_r   <= ext_log(a_occ_r) + sm_prod;
          state_r <= S_DET_B;
        end
        S_DET_B: begin
          acc_r   <= acc_r + sm_prod;
          state_r <= S_DET_C;
        end
        S_DET_C: begin
          run_r   <= sadd(run_r, t1_v);
          a_occ_r <= '0;
          a_un_r  <= LOG_NEG;
          state_r <= S_TR_GO;
        end
        // no detection: normalise the pair
        S_ND_A: begin
          acc_r   <= ext_log(a_occ_r) + sm_prod;
          state_r <= S_ND_B;
        end
        S_ND_B: begin
          t1_r    <= t1_v;
          hi_r    <= lse_hi;
          state_r <= S_ND_WAIT;
        end
        S_ND_WAIT: begin
          if (corr_rsp.done) begin
            nrm_r   <= lse_res;
            state_r <= S_ND_C;
          end
        end
        S_ND_C: begin
          run_r   <= sadd(run_r, nrm_r);
          a_occ_r <= sadd(t1_r, neg_nrm);
          a_un_r  <= sadd(a_un_r, neg_nrm);
          state_r <= S_TR_GO;
        end
        // transition, both sums from the old pair
        S_TR_GO: begin
          if (last_r) begin
            state_r <= S_EMIT;
          end else begin
            hi_r    <= lse_hi;
            state_r <= S_TR_W1;
          end
        end
        S_TR_W1: begin
          if (corr_rsp.done) begin
            tmp_r   <= lse_res;
            state_r <= S_TR_GO2;
          end
        end
        S_TR_GO2: begin
          hi_r    <= lse_hi;
          state_r <= S_TR_W2;
        end
        S_TR_W2: begin
          if (corr_rsp.done) begin
            a_occ_r <= tmp_r;
            a_un_r  <= lse_res;
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_loglik_r <= run_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // correction results arrive only while a wait state expects one
  a_corr_wait: assert property (@(posedge clk) disable iff (!rst_n)
    corr_rsp.done |-> (state_r == S_ETA_WAIT || state_r == S_ND_WAIT ||
                       state_r == S_TR_W1 || state_r == S_TR_W2))
    else $error("unexpected correction result");

  // a fresh result comes only from the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r) == S_EMIT)
    else $error("result raised outside emit");

  // a known-occupied season leaves the unoccupied state at the floor
  a_det_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DET_C) |=> (a_un_r == LOG_NEG && a_occ_r == '0))
    else $error("known-occupied update wrong");

  // a transfer in always starts a busy period
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block ready straight after a transfer");

endmodule
